@@ rtl/tes_pkg.sv @@
// Package for the tone effect sequencer: codes, note record and the effect tables.
package tes_pkg;

   // Request kinds carried on the input tuser.
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2
   } req_kind_type;

   // Buzzer actions carried on the result tuser.
   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_TONE    = 2'd1,
      ACT_SILENCE = 2'd2
   } action_type;

   // Effect codes; codes at or above EFFECT_COUNT have no table entry.
   localparam logic [2:0] EFF_NONE    = 3'd0;
   localparam logic [2:0] EFF_CLICK   = 3'd1;
   localparam logic [2:0] EFF_RADAR   = 3'd2;
   localparam logic [2:0] EFF_CHIRP   = 3'd3;
   localparam logic [2:0] EFF_POWERUP = 3'd4;
   localparam logic [2:0] EFFECT_COUNT = 3'd5;

   // One note of an effect.
   typedef struct packed {
      logic [10:0] freq;
      logic [7:0]  len;
      logic [7:0]  gap;
   } note_type;

   // Per-effect summary: number of notes and tail length in ms.
   typedef struct packed {
      logic [1:0] notes;
      logic [7:0] tail_ms;
   } effect_type;

   // Note table lookup by effect and note position.
   function automatic note_type effect_note(input logic [2:0] effect, input logic [1:0] idx);
      note_type n;
      n = '0;
      case (effect)
         EFF_CLICK: begin
            if (idx == 2'd0) n = '{11'd1800, 8'd18, 8'd22};
         end
         EFF_RADAR: begin
            case (idx)
               2'd0:    n = '{11'd1500, 8'd14, 8'd18};
               2'd1:    n = '{11'd980,  8'd50, 8'd60};
               2'd2:    n = '{11'd1220, 8'd55, 8'd70};
               default: n = '0;
            endcase
         end
         EFF_CHIRP: begin
            case (idx)
               2'd0:    n = '{11'd940,  8'd55, 8'd65};
               2'd1:    n = '{11'd1160, 8'd55, 8'd65};
               2'd2:    n = '{11'd860,  8'd80, 8'd95};
               default: n = '0;
            endcase
         end
         EFF_POWERUP: begin
            case (idx)
               2'd0:    n = '{11'd780,  8'd70, 8'd78};
               2'd1:    n = '{11'd1080, 8'd70, 8'd78};
               2'd2:    n = '{11'd1420, 8'd90, 8'd105};
               default: n = '0;
            endcase
         end
         default: n = '0;
      endcase
      return n;
   endfunction

   // Effect summary lookup.
   function automatic effect_type effect_info(input logic [2:0] effect);
      effect_type e;
      case (effect)
         EFF_CLICK:   e = '{2'd1, 8'd110};
         EFF_RADAR:   e = '{2'd3, 8'd140};
         EFF_CHIRP:   e = '{2'd3, 8'd130};
         EFF_POWERUP: e = '{2'd3, 8'd160};
         default:     e = '0;
      endcase
      return e;
   endfunction

endpackage

@@ rtl/tone_effect_sequencer.sv @@
// Top level of the tone effect sequencer: input stage, note sequencing and result register.
//
// The sequencer plays fixed buzzer effects (click, radar, chirp, power-up). Each input
// item is a tick, a start or a stop, and each produces exactly one result item. An item
// sits in an input register, where a small table lookup, a 32-bit due-time compare and
// the state update happen, and its result is then held in an output register. One item
// is taken every cycle while the result side keeps up; an accepted item passes through
// the input register and then the output register before its result is valid. A stalled
// result holds the block only once both the input register and the output register are
// full.
module tone_effect_sequencer
   import tes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input item stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sound_id [2:0], now_ms [34:3], zero fill [39:35]
   input  logic [1:0]  req_tuser,   // req_type [1:0]
   // Result item stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // tone_freq_hz [10:0], tone_len_ms [18:11],
                                    // busy_res [19], tail_freq_hz [30:20],
                                    // tail_start_ms [62:31], tail_end_ms [94:63],
                                    // zero fill [95]
   output logic [1:0]  rsp_tuser    // action [1:0]
);

   // Input stage registers.
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_kind_ff;
   logic [2:0]  in_sound_ff;
   logic [31:0] in_now_ff;

   // Sequencer state.
   logic [2:0]  active_ff, active_in;
   logic [1:0]  index_ff, index_in;
   logic [31:0] due_ff, due_in;
   logic [10:0] last_freq_ff, last_freq_in;
   logic [10:0] tail_freq_ff, tail_freq_in;
   logic [31:0] tail_start_ff, tail_start_in;
   logic [31:0] tail_end_ff, tail_end_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_action_ff;
   logic [95:0] out_data_ff;

   logic        advance;
   logic [1:0]  action;
   logic [10:0] tone_freq;
   logic [7:0]  tone_len;
   logic [31:0] elapsed;
   note_type    note;
   effect_type  info;

   // Handshake: the input register moves on when the output register is free or drained.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Table lookups and due test for the current effect.
   assign note    = effect_note(active_ff, index_ff);
   assign info    = effect_info(active_ff);
   assign elapsed = in_now_ff - due_ff;

   // Request decode and state update for the item in the input register.
   always_comb begin
      active_in     = active_ff;
      index_in      = index_ff;
      due_in        = due_ff;
      last_freq_in  = last_freq_ff;
      tail_freq_in  = tail_freq_ff;
      tail_start_in = tail_start_ff;
      tail_end_in   = tail_end_ff;
      action        = ACT_NONE;
      tone_freq     = '0;
      tone_len      = '0;
      case (in_kind_ff)
         REQ_TICK: begin
            if (active_ff != EFF_NONE && !elapsed[31]) begin
               if (active_ff >= EFFECT_COUNT) begin
                  // Unknown effect: silence and drop back to idle.
                  active_in = EFF_NONE;
                  action    = ACT_SILENCE;
               end else if (index_ff < info.notes) begin
                  // Next note is due.
                  action       = ACT_TONE;
                  tone_freq    = note.freq;
                  tone_len     = note.len;
                  last_freq_in = note.freq;
                  due_in       = in_now_ff + {24'd0, note.gap};
                  index_in     = index_ff + 2'd1;
               end else begin
                  // Past the last note: record the tail and go idle.
                  action        = ACT_SILENCE;
                  tail_freq_in  = last_freq_ff;
                  tail_start_in = in_now_ff;
                  tail_end_in   = in_now_ff + {24'd0, info.tail_ms};
                  active_in     = EFF_NONE;
               end
            end
         end
         REQ_START: begin
            active_in   = in_sound_ff;
            index_in    = '0;
            due_in      = in_now_ff;
            tail_end_in = '0;
         end
         REQ_STOP: begin
            action      = ACT_SILENCE;
            active_in   = EFF_NONE;
            tail_end_in = '0;
         end
         default: begin
            action = ACT_NONE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sequencer state, updated as each item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= EFF_NONE;
         index_ff      <= '0;
         due_ff        <= '0;
         last_freq_ff  <= '0;
         tail_freq_ff  <= '0;
         tail_start_ff <= '0;
         tail_end_ff   <= '0;
      end else if (advance) begin
         active_ff     <= active_in;
         index_ff      <= index_in;
         due_ff        <= due_in;
         last_freq_ff  <= last_freq_in;
         tail_freq_ff  <= tail_freq_in;
         tail_start_ff <= tail_start_in;
         tail_end_ff   <= tail_end_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff  <= req_tuser;
         in_sound_ff <= req_tdata[2:0];
         in_now_ff   <= req_tdata[34:3];
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_action_ff <= action;
         out_data_ff   <= {1'b0, tail_end_in, tail_start_in, tail_freq_in,
                           (active_in != EFF_NONE), tone_len, tone_freq};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_action_ff;

endmodule

@@ tb/tone_effect_sequencer_tb.sv @@
// Testbench for tone_effect_sequencer: a directed table and random runs checked by a predictor.
`timescale 1ns / 1ps

module tone_effect_sequencer_tb;
   import tes_pkg::*;

   // Codes the package leaves unnamed: the unused request kind and the top effect code.
   localparam logic [1:0] REQ_UNUSED    = 2'd3;
   localparam logic [2:0] EFF_UNDEF_MAX = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  effect;
      logic [31:0] now;
   } tone_req_t;

   typedef struct packed {
      action_type  action;
      logic [10:0] freq;
      logic [7:0]  len;
      logic        busy;
      logic [10:0] tail_freq;
      logic [31:0] tail_start;
      logic [31:0] tail_end;
   } tone_rsp_t;

   typedef struct {
      tone_req_t req;
      bit        fixed;
      tone_rsp_t rsp;
   } stim_row_t;

   localparam tone_rsp_t IDLE_RSP = '0;
   localparam tone_rsp_t BUSY_RSP = '{ACT_NONE, 11'd0, 8'd0, 1'b1, 11'd0, 32'd0, 32'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // sound_id [2:0], now_ms [34:3], zero fill [39:35]
   logic [1:0]  req_tuser = '0;   // req_type [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // tone_freq_hz [10:0], tone_len_ms [18:11], busy_res [19],
                                  // tail_freq_hz [30:20], tail_start_ms [62:31],
                                  // tail_end_ms [94:63], zero fill [95]
   logic [1:0]  rsp_tuser;        // action [1:0]

   // Predicted sequencer state.
   logic [2:0]  cur_effect = EFF_NONE;
   logic [1:0]  note_pos = 2'd0;
   logic [31:0] due_ms = '0;
   logic [10:0] last_freq = '0;
   logic [10:0] tail_freq_q = '0;
   logic [31:0] tail_start_q = '0;
   logic [31:0] tail_end_q = '0;

   tone_rsp_t pending_buzzer_results [$];
   stim_row_t directed_rows [$];

   int error_count = 0;
   int sent_count = 0;
   int burst_left = 0;
   int send_idle_pct = 15;
   bit quiet = 1'b0;
   bit hold_pending = 1'b0;

   tone_effect_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Reset is held at the start and never again.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Ends a run that hangs.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Note table of each effect.
   function automatic note_type effect_note_at(input logic [2:0] effect, input logic [1:0] pos);
      note_type n;
      n = '0;
      case ({effect, pos})
         {EFF_CLICK, 2'd0}:   n = '{11'd1800, 8'd18, 8'd22};
         {EFF_RADAR, 2'd0}:   n = '{11'd1500, 8'd14, 8'd18};
         {EFF_RADAR, 2'd1}:   n = '{11'd980, 8'd50, 8'd60};
         {EFF_RADAR, 2'd2}:   n = '{11'd1220, 8'd55, 8'd70};
         {EFF_CHIRP, 2'd0}:   n = '{11'd940, 8'd55, 8'd65};
         {EFF_CHIRP, 2'd1}:   n = '{11'd1160, 8'd55, 8'd65};
         {EFF_CHIRP, 2'd2}:   n = '{11'd860, 8'd80, 8'd95};
         {EFF_POWERUP, 2'd0}: n = '{11'd780, 8'd70, 8'd78};
         {EFF_POWERUP, 2'd1}: n = '{11'd1080, 8'd70, 8'd78};
         {EFF_POWERUP, 2'd2}: n = '{11'd1420, 8'd90, 8'd105};
         default:             n = '0;
      endcase
      return n;
   endfunction

   // Number of notes and tail length of each effect.
   function automatic effect_type effect_summary(input logic [2:0] effect);
      effect_type e;
      case (effect)
         EFF_CLICK:   e = '{2'd1, 8'd110};
         EFF_RADAR:   e = '{2'd3, 8'd140};
         EFF_CHIRP:   e = '{2'd3, 8'd130};
         EFF_POWERUP: e = '{2'd3, 8'd160};
         default:     e = '0;
      endcase
      return e;
   endfunction

   // Advances the predicted state by one accepted item and returns its result.
   task automatic play_effect_step(input tone_req_t r, output tone_rsp_t res);
      logic [31:0] lag;
      note_type    n;
      effect_type  e;
      res = '0;
      lag = r.now - due_ms;
      if (r.kind == REQ_TICK) begin
         // Only a due tick of a playing effect changes anything.
         if (cur_effect != EFF_NONE && !lag[31]) begin
            if (cur_effect >= EFFECT_COUNT) begin
               cur_effect = EFF_NONE;
               res.action = ACT_SILENCE;
            end else begin
               e = effect_summary(cur_effect);
               if (note_pos < e.notes) begin
                  n = effect_note_at(cur_effect, note_pos);
                  last_freq = n.freq;
                  res.action = ACT_TONE;
                  res.freq = n.freq;
                  res.len = n.len;
                  due_ms = r.now + {24'd0, n.gap};
                  note_pos = note_pos + 2'd1;
               end else begin
                  // Past the last note: silence and record the fading tail.
                  tail_freq_q = last_freq;
                  tail_start_q = r.now;
                  tail_end_q = r.now + {24'd0, e.tail_ms};
                  cur_effect = EFF_NONE;
                  res.action = ACT_SILENCE;
               end
            end
         end
      end else if (r.kind == REQ_START) begin
         cur_effect = r.effect;
         note_pos = 2'd0;
         due_ms = r.now;
         tail_end_q = '0;
      end else if (r.kind == REQ_STOP) begin
         res.action = ACT_SILENCE;
         cur_effect = EFF_NONE;
         tail_end_q = '0;
      end
      res.busy = (cur_effect != EFF_NONE);
      res.tail_freq = tail_freq_q;
      res.tail_start = tail_start_q;
      res.tail_end = tail_end_q;
   endtask

   function automatic void add_row(input logic [1:0] kind, input logic [2:0] effect,
                                   input logic [31:0] now, input bit fixed,
                                   input tone_rsp_t rsp);
      stim_row_t row;
      row.req = '{kind, effect, now};
      row.fixed = fixed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endfunction

   // Offers one item, waits for it to be taken, records its expected result and maybe idles.
   task automatic offer_request(input tone_req_t r, input bit fixed, input tone_rsp_t typed_rsp);
      tone_rsp_t predicted;
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {5'b0, r.now, r.effect};
      do @(posedge clock); while (!req_tready);
      play_effect_step(r, predicted);
      pending_buzzer_results.push_back(fixed ? typed_rsp : predicted);
      if (r.kind != REQ_UNUSED) sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Compares one field of a result item.
   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Result checker: every item taken on the result side is matched with the oldest expectation.
   always @(posedge clock) begin
      tone_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_buzzer_results.size() == 0) begin
            $error("result item with no expectation waiting");
            error_count++;
         end else begin
            want = pending_buzzer_results.pop_front();
            check_field("action", 32'(want.action), 32'(rsp_tuser));
            check_field("tone_freq_hz", 32'(want.freq), 32'(rsp_tdata[10:0]));
            check_field("tone_len_ms", 32'(want.len), 32'(rsp_tdata[18:11]));
            check_field("busy_res", 32'(want.busy), 32'(rsp_tdata[19]));
            check_field("tail_freq_hz", 32'(want.tail_freq), 32'(rsp_tdata[30:20]));
            check_field("tail_start_ms", want.tail_start, rsp_tdata[62:31]);
            check_field("tail_end_ms", want.tail_end, rsp_tdata[94:63]);
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      int stall_pct;
      stall_pct = 20;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 63) == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (90) @(posedge clock);
            hold_pending = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Stimulus: directed table first, then random effect runs and noise.
   initial begin : stimulus
      tone_req_t r;
      int        guard;
      bit        hold_done;
      hold_done = 1'b0;

      // Idle block, both ends of the time range and the unused request kind.
      add_row(REQ_TICK, EFF_NONE, 32'd0, 1'b1, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'hFFFF_FFFF, 1'b1, IDLE_RSP);
      add_row(REQ_UNUSED, EFF_UNDEF_MAX, 32'hFFFF_FFFF, 1'b1, IDLE_RSP);
      add_row(REQ_STOP, EFF_NONE, 32'd5, 1'b1,
              '{ACT_SILENCE, 11'd0, 8'd0, 1'b0, 11'd0, 32'd0, 32'd0});
      add_row(REQ_START, EFF_NONE, 32'd100, 1'b1, IDLE_RSP);
      // Click: not yet due, first note, then the tail.
      add_row(REQ_START, EFF_CLICK, 32'd1000, 1'b1, BUSY_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'd999, 1'b1, BUSY_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'd1000, 1'b1,
              '{ACT_TONE, 11'd1800, 8'd18, 1'b1, 11'd0, 32'd0, 32'd0});
      add_row(REQ_TICK, EFF_NONE, 32'd1021, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'd1022, 1'b0, IDLE_RSP);
      // Radar across the wrap of the millisecond counter.
      add_row(REQ_START, EFF_RADAR, 32'hFFFF_FFF0, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'hFFFF_FFF0, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h0000_0002, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h0000_003E, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h0000_0084, 1'b0, IDLE_RSP);
      // Chirp near the signed midpoint, replaced by power-up, then stopped.
      add_row(REQ_START, EFF_CHIRP, 32'h7FFF_FFFF, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h7FFF_FFFF, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h8000_0000, 1'b0, IDLE_RSP);
      add_row(REQ_START, EFF_POWERUP, 32'h8000_0000, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h8000_0000, 1'b0, IDLE_RSP);
      add_row(REQ_STOP, EFF_NONE, 32'h8000_0001, 1'b0, IDLE_RSP);
      // Unknown effect codes: busy until the first due tick, then silence.
      add_row(REQ_START, EFFECT_COUNT, 32'd10, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'd9, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'd10, 1'b0, IDLE_RSP);
      add_row(REQ_START, EFF_UNDEF_MAX, 32'd20, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'hFFFF_FFFF, 1'b0, IDLE_RSP);
      add_row(REQ_TICK, EFF_NONE, 32'h8000_0013, 1'b0, IDLE_RSP);

      @(negedge reset);
      @(posedge clock);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

      // Random part: mostly whole effect runs, the rest noise.
      while (sent_count < 850) begin
         if (sent_count >= 750) quiet = 1'b1;
         if (!hold_done && sent_count >= 200) begin
            hold_pending = 1'b1;
            burst_left = 40;
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 31) == 0) send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         if ($urandom_range(0, 3) != 0) begin
            r.kind = REQ_START;
            if ($urandom_range(0, 9) == 0)
               r.effect = $urandom_range(0, 1) ? EFF_NONE :
                          3'($urandom_range(EFFECT_COUNT, EFF_UNDEF_MAX));
            else r.effect = 3'($urandom_range(EFF_CLICK, EFF_POWERUP));
            r.now = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FF80 + $urandom_range(0, 127) : $urandom;
            offer_request(r, 1'b0, IDLE_RSP);
            guard = 0;
            // Ticks around the next due time until the effect ends or twelve items are sent.
            while (cur_effect != EFF_NONE && guard < 12) begin
               r.kind = REQ_TICK;
               r.effect = 3'($urandom_range(0, 7));
               case ($urandom_range(0, 9))
                  0, 1, 2: r.now = due_ms;
                  3, 4, 5, 6: r.now = due_ms + $urandom_range(1, 40);
                  7, 8: r.now = due_ms - $urandom_range(1, 30);
                  default: begin
                     r.kind = 2'($urandom_range(REQ_START, REQ_UNUSED));
                     r.now = due_ms + $urandom_range(0, 50);
                  end
               endcase
               offer_request(r, 1'b0, IDLE_RSP);
               guard++;
            end
         end else begin
            r.kind = 2'($urandom_range(0, 3));
            r.effect = 3'($urandom_range(0, 7));
            r.now = $urandom;
            offer_request(r, 1'b0, IDLE_RSP);
         end
      end

      // Drain and let the pipeline settle.
      req_tvalid <= 1'b0;
      while (pending_buzzer_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
